// ===== sv/mkced_pkg.sv =====
// Shared types and constants for the multi-key click event detector.
// No dependencies; imported by the top level and the key-state RAM users.
package mkced_pkg;

  localparam int NUM_KEYS = 4;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LEVEL_W  = 4;

  localparam int TIMER_W  = 16;
  localparam int SCAN_W   = 5;
  localparam int FLAGS_W  = 7;
  localparam int PHASE_W  = 3;
  localparam int CFG_IDX_W = 2;

  // event flag bit positions
  localparam int FL_HOLD   = 0;
  localparam int FL_DOWN   = 1;
  localparam int FL_UP     = 2;
  localparam int FL_SINGLE = 3;
  localparam int FL_DOUBLE = 4;
  localparam int FL_LONG   = 5;
  localparam int FL_REPEAT = 6;

  localparam logic [FLAGS_W-1:0] FLAG_HOLD = 7'h01;

  // per-key press phases as stored in the RAM
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_GAP      = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SECOND   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_REPEAT   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN       = 2'd3;

  localparam logic [TIMER_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [TIMER_W-1:0] DOUBLE_GAP_RST = 16'd200;
  localparam logic [TIMER_W-1:0] REPEAT_RST     = 16'd100;
  localparam logic [SCAN_W-1:0]  SCAN_RST       = 5'd20;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef struct packed {
    logic                 level;
    logic [PHASE_W-1:0]   phase;
    logic [TIMER_W-1:0]   timer;
    logic [FLAGS_W-1:0]   flags;
  } key_entry_t;

  localparam int ENTRY_W = $bits(key_entry_t);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_CHECK  = 4'b0100,
    S_RESULT = 4'b1000
  } ctrl_state_t;

endpackage

// ===== sv/multi_key_click_event_detector_unit.sv =====
// Multi-key click event detector: debounce, press phase machine and event flags.
// Depends on mkced_pkg and mkced_ram (per-key state store).
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall  | action, key_levels, key_index, flag_mask
//   out_    | output    | out_valid / out_stall| hit, flags_seen
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// A tick does one RAM read-modify-write per key through the single key-state RAM,
// plus issue and result. A check does issue, check and result; the check step is
// skipped when the key is out of range.
// One beat is in flight at a time; in_stall is high from accept until the result
// is loaded into the output register, which holds it while out_stall is high.
// in_stall is also high while a register write is offered, so the write goes first.
// Synchronous active-low reset; per-key state reads as zero until first written.
module multi_key_click_event_detector_unit
  import mkced_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [LEVEL_W-1:0]    in_key_levels,
  input  logic [4:0]            in_key_index,
  input  logic [FLAGS_W-1:0]    in_flag_mask,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic [FLAGS_W-1:0]    out_flags_seen,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIMER_W-1:0]    cfg_wdata
);

  localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

  ctrl_state_t          state_r, state_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [NUM_KEYS-1:0]  vld_r;
  logic [SCAN_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                 sample_r;
  logic [LEVEL_W-1:0]   levels_r;
  logic [FLAGS_W-1:0]   mask_r;

  logic [TIMER_W-1:0]   long_press_r, double_gap_r, repeat_r;
  logic [SCAN_W-1:0]    scan_period_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [FLAGS_W-1:0]   out_flags_r, out_flags_nxt;
  logic                 res_hit_r, res_hit_nxt;
  logic [FLAGS_W-1:0]   res_flags_r, res_flags_nxt;

  logic                 in_acc;
  logic                 idx_ok;
  logic [SCAN_W-1:0]    sc_inc;
  logic                 sc_sample;

  logic                 ram_we;
  logic [KEY_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  key_entry_t           cur, tick_upd, chk_upd, wr_entry;
  logic                 key_now, prev;
  logic [5:0]           key_num;
  logic                 chk_hit;

  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign idx_ok    = ({1'b0, in_key_index} < 6'(NUM_KEYS));

  // scan divider; a period of 0 behaves as 1
  assign sc_inc    = scan_cnt_r + SCAN_W'(1);
  assign sc_sample = (sc_inc >= scan_period_r) || (sc_inc == '0);

  // entries never written read as the reset state
  always_comb begin
    cur = key_entry_t'(ram_rdata);
    if (!vld_r[key_r]) begin
      cur = '0;
    end
  end

  // keys past the level vector sample as released
  assign key_num = 6'(key_r);
  assign key_now = (key_num < 6'(LEVEL_W)) ? levels_r[key_num[1:0]] : 1'b0;
  assign prev    = cur.level;

  always_comb begin
    tick_upd = cur;
    if (tick_upd.timer != '0) begin
      tick_upd.timer = tick_upd.timer - TIMER_W'(1);
    end
    if (sample_r) begin
      tick_upd.level          = key_now;
      tick_upd.flags[FL_HOLD] = key_now;
      if (key_now && !prev) begin
        tick_upd.flags[FL_DOWN] = 1'b1;
      end
      if (!key_now && prev) begin
        tick_upd.flags[FL_UP] = 1'b1;
      end
      case (cur.phase)
        PH_IDLE: begin
          if (key_now) begin
            tick_upd.timer = long_press_r;
            tick_upd.phase = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (!key_now) begin
            tick_upd.timer = double_gap_r;
            tick_upd.phase = PH_GAP;
          end else if (tick_upd.timer == '0) begin
            tick_upd.timer          = repeat_r;
            tick_upd.flags[FL_LONG] = 1'b1;
            tick_upd.phase          = PH_REPEAT;
          end
        end
        PH_GAP: begin
          if (key_now) begin
            tick_upd.flags[FL_DOUBLE] = 1'b1;
            tick_upd.phase            = PH_SECOND;
          end else if (tick_upd.timer == '0) begin
            tick_upd.flags[FL_SINGLE] = 1'b1;
            tick_upd.phase            = PH_IDLE;
          end
        end
        PH_SECOND: begin
          if (!key_now) begin
            tick_upd.phase = PH_IDLE;
          end
        end
        PH_REPEAT: begin
          if (!key_now) begin
            tick_upd.phase = PH_IDLE;
          end else if (tick_upd.timer == '0) begin
            tick_upd.timer            = repeat_r;
            tick_upd.flags[FL_REPEAT] = 1'b1;
          end
        end
        default: begin
          tick_upd.phase = PH_IDLE;
        end
      endcase
    end
  end

  assign chk_hit = |(cur.flags & mask_r);

  always_comb begin
    chk_upd       = cur;
    chk_upd.flags = cur.flags & ~mask_r;
  end

  // writes and the next read never touch the same entry in one cycle
  always_comb begin
    ram_we   = 1'b0;
    wr_entry = tick_upd;
    case (state_r)
      S_SWEEP: ram_we = 1'b1;
      S_CHECK: begin
        ram_we   = chk_hit && (mask_r != FLAG_HOLD);
        wr_entry = chk_upd;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_comb begin
    ram_raddr = key_r + KEY_W'(1);
    if (state_r == S_IDLE) begin
      ram_raddr = (in_action == ACT_CHECK) ? in_key_index[KEY_W-1:0] : '0;
    end
  end

  mkced_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_KEYS)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_r),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    scan_cnt_nxt  = scan_cnt_r;
    res_hit_nxt   = res_hit_r;
    res_flags_nxt = res_flags_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_flags_nxt = out_flags_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_hit_nxt   = 1'b0;
          res_flags_nxt = '0;
          if (in_action == ACT_TICK) begin
            key_nxt      = '0;
            scan_cnt_nxt = sc_sample ? '0 : sc_inc;
            state_nxt    = S_SWEEP;
          end else if (idx_ok) begin
            key_nxt   = in_key_index[KEY_W-1:0];
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SWEEP: begin
        key_nxt = key_r + KEY_W'(1);
        if (key_r == LAST_KEY) begin
          key_nxt   = key_r;
          state_nxt = S_RESULT;
        end
      end
      S_CHECK: begin
        res_hit_nxt   = chk_hit;
        res_flags_nxt = cur.flags;
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_flags_nxt = res_flags_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      key_r         <= '0;
      vld_r         <= '0;
      scan_cnt_r    <= '0;
      out_valid_r   <= 1'b0;
      long_press_r  <= LONG_PRESS_RST;
      double_gap_r  <= DOUBLE_GAP_RST;
      repeat_r      <= REPEAT_RST;
      scan_period_r <= SCAN_RST;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        vld_r[key_r] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LONG_PRESS: long_press_r  <= cfg_wdata;
          REG_DOUBLE_GAP: double_gap_r  <= cfg_wdata;
          REG_REPEAT:     repeat_r      <= cfg_wdata;
          REG_SCAN:       scan_period_r <= cfg_wdata[SCAN_W-1:0];
          default:        scan_period_r <= scan_period_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      levels_r <= in_key_levels;
      mask_r   <= in_flag_mask;
      sample_r <= sc_sample;
    end
    res_hit_r   <= res_hit_nxt;
    res_flags_r <= res_flags_nxt;
    out_hit_r   <= out_hit_nxt;
    out_flags_r <= out_flags_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_flags_seen = out_flags_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state not one-hot");

  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SWEEP || state_r == S_CHECK))
    else $error("key RAM written outside a sweep or check");

  a_check_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> $past(in_acc))
    else $error("check cycle without an accepted beat");

  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && key_r == LAST_KEY) |=> (state_r == S_RESULT))
    else $error("sweep did not end after the last key");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && out_valid_r && out_stall) |=> (state_r == S_RESULT))
    else $error("result dropped while output held");

endmodule

// ===== sv/mkced_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mkced_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
